// File: hw/rtl/mavg_pkg.sv
// Shared types and constants for the moving average window unit.
// No dependencies; imported by the register block, the divider, the top level and the testbench.
package mavg_pkg;

  localparam int DATA_W    = 16;
  localparam int WSIZE_W   = 5;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [WSIZE_W-1:0] WSIZE_RST = 5'd16;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_WINDOW_SIZE = 1'b0,
    REG_SIGNED_MODE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [WSIZE_W-1:0] window_size;
    logic               signed_mode;
    logic               wr;          // any register write this cycle
  } cfg_t;

endpackage

// File: hw/rtl/mavg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mavg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/mavg_cfg.sv
// APB register block: window_size and signed_mode.
// Depends on mavg_pkg.
module mavg_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mavg_pkg::APB_AW-1:0] paddr,
  input  logic [mavg_pkg::APB_DW-1:0] pwdata,
  output logic [mavg_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output mavg_pkg::cfg_t             cfg
);
  import mavg_pkg::*;

  logic [WSIZE_W-1:0] window_size;
  logic               signed_mode;
  logic               wr_en;
  reg_idx_t           idx;

  // low address bits are not decoded
  assign idx    = reg_idx_t'(paddr[2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WSIZE_RST;
      signed_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_WINDOW_SIZE: window_size <= pwdata[WSIZE_W-1:0];
        REG_SIGNED_MODE: signed_mode <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WINDOW_SIZE: prdata = APB_DW'(window_size);
      REG_SIGNED_MODE: prdata = APB_DW'(signed_mode);
    endcase
  end

  assign cfg.window_size = window_size;
  assign cfg.signed_mode = signed_mode;
  assign cfg.wr          = wr_en;

endmodule

// File: hw/rtl/mavg_div.sv
// Bit-serial restoring divider: signed sum by unsigned count, truncating toward zero.
// Depends on mavg_pkg for the result width.
module mavg_div #(
  parameter int SUM_W = 21,
  parameter int CNT_W = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [SUM_W-1:0]     sum,
  input  logic [CNT_W-1:0]            divisor,
  output logic                        busy,
  output logic [mavg_pkg::DATA_W-1:0] quotient
);
  import mavg_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic [SUM_W-1:0]  dvd;     // dividend shifts out, quotient shifts in
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dsr;
  logic              neg;
  logic [STEP_W-1:0] step;
  logic [CNT_W:0]    trial;
  logic              ge;
  logic [CNT_W:0]    diff;

  assign trial = {rem, dvd[SUM_W-1]};
  assign ge    = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      neg  <= sum[SUM_W-1];
      dvd  <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      rem  <= '0;
      dsr  <= divisor;
      step <= STEP_W'(SUM_W - 1);
    end else if (busy) begin
      rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      dvd <= {dvd[SUM_W-2:0], ge};
      if (step == '0) begin
        busy <= 1'b0;
      end else begin
        step <= step - 1'b1;
      end
    end
  end

  assign quotient = neg ? DATA_W'(-dvd[DATA_W-1:0]) : dvd[DATA_W-1:0];

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    busy |-> (dsr != '0))
    else $error("divide by zero count");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("divider did not start");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem < dsr))
    else $error("partial remainder not below divisor");

endmodule

// File: hw/rtl/moving_average_window_unit.sv
// Moving average over a ring of recent samples, one result beat per input beat.
// Each sample beat steps through S_READ, S_START, S_DIV and S_DONE; S_DIV waits on the
// bit-serial divider (one quotient bit per cycle). A clear beat goes straight to S_DONE.
// One beat in flight: a new beat is taken only in S_IDLE; output stalls hold S_DONE.
// Reset (rst, synchronous): window empty, sum, position and count zero, window_size 16.
// Depends on mavg_pkg, mavg_cfg, mavg_ram, mavg_div.
module moving_average_window_unit #(
  parameter int MAX_WINDOW = 16,
  localparam int CNT_W = $clog2(MAX_WINDOW + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mavg_pkg::APB_AW-1:0] paddr,
  input  logic [mavg_pkg::APB_DW-1:0] pwdata,
  output logic [mavg_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mavg_pkg::DATA_W-1:0] sample,
  input  logic                        clear,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mavg_pkg::DATA_W-1:0] average,
  output logic [CNT_W-1:0]            sample_count
);
  import mavg_pkg::*;

  localparam int POS_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W = DATA_W + 1 + $clog2(MAX_WINDOW);
  localparam int CMP_W = 9;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_START,
    S_DIV,
    S_DONE
  } state_t;

  state_t                   state;
  cfg_t                     cfg;
  logic signed [SUM_W-1:0]  sum;
  logic [POS_W-1:0]         wpos;
  logic [CNT_W-1:0]         vcount;
  logic [POS_W-1:0]         pos;
  logic [DATA_W-1:0]        samp;
  logic                     full;
  logic                     res_clr;

  logic [WSIZE_W-1:0]       ws1;
  logic [CNT_W-1:0]         size_eff;
  logic [POS_W-1:0]         pos_cur;
  logic [CNT_W-1:0]         pos_inc;
  logic [POS_W-1:0]         pos_nxt;
  logic                     accept;
  logic [DATA_W-1:0]        rdata;
  logic signed [SUM_W-1:0]  new_val;
  logic signed [SUM_W-1:0]  old_val;
  logic signed [SUM_W-1:0]  sum_next;
  logic                     div_busy;
  logic [DATA_W-1:0]        quot;

  mavg_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // window size: zero reads as one, saturates at the built depth
  assign ws1 = (cfg.window_size == '0) ? WSIZE_W'(1) : cfg.window_size;
  assign size_eff = (CMP_W'(ws1) > CMP_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW)
                                                       : CNT_W'(ws1);

  assign pos_cur = (CNT_W'(wpos) >= size_eff) ? '0 : wpos;
  assign pos_inc = CNT_W'(pos) + CNT_W'(1);
  assign pos_nxt = (pos_inc >= size_eff) ? '0 : POS_W'(pos_inc);

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  mavg_ram #(.WIDTH(DATA_W), .DEPTH(MAX_WINDOW)) u_ring (
    .clk,
    .we    (state == S_READ),
    .waddr (pos),
    .wdata (samp),
    .re    (accept && !clear),
    .raddr (pos_cur),
    .rdata (rdata)
  );

  always_comb begin
    new_val = cfg.signed_mode ? SUM_W'($signed(samp)) : SUM_W'($signed({1'b0, samp}));
    if (!full) begin
      old_val = '0;
    end else if (cfg.signed_mode) begin
      old_val = SUM_W'($signed(rdata));
    end else begin
      old_val = SUM_W'($signed({1'b0, rdata}));
    end
    sum_next = sum + new_val - old_val;
  end

  mavg_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div (
    .clk,
    .rst,
    .start    (state == S_START),
    .sum      (sum),
    .divisor  (vcount),
    .busy     (div_busy),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      sum       <= '0;
      wpos      <= '0;
      vcount    <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.wr) begin
        sum    <= '0;
        wpos   <= '0;
        vcount <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (clear) begin
              sum     <= '0;
              wpos    <= '0;
              vcount  <= '0;
              res_clr <= 1'b1;
              state   <= S_DONE;
            end else begin
              samp    <= sample;
              pos     <= pos_cur;
              full    <= (vcount >= size_eff);
              res_clr <= 1'b0;
              state   <= S_READ;
            end
          end
        end
        S_READ: begin
          // ring data for the oldest entry arrives this cycle
          sum  <= sum_next;
          wpos <= pos_nxt;
          if (!full) begin
            vcount <= vcount + 1'b1;
          end
          state <= S_START;
        end
        S_START: state <= S_DIV;
        S_DIV: begin
          if (!div_busy) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            average      <= res_clr ? '0 : quot;
            sample_count <= vcount;
            state        <= S_IDLE;
          end
        end
      endcase
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second beat taken while one is in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    vcount <= size_eff)
    else $error("valid count exceeds window size");

  a_sample_counts: assert property (@(posedge clk) disable iff (rst)
    accept && !clear |-> ##2 (vcount != '0))
    else $error("count not advanced after sample beat");

  a_empty_avg: assert property (@(posedge clk) disable iff (rst)
    out_valid && (sample_count == '0) |-> (average == '0))
    else $error("nonzero average with empty window");

endmodule

// File: verif/tb_moving_average_window_unit.sv
// Self-checking testbench for moving_average_window_unit: a random-burst beat driver,
// a stalling result sink and an in-line average predictor with APB register writes.
// Depends on mavg_pkg and the moving_average_window_unit RTL.
`timescale 1ns / 1ps

module tb_moving_average_window_unit;
  import mavg_pkg::*;

  localparam int MAX_WINDOW  = 16;
  localparam int CNT_W       = 5;
  localparam int PHASE_BEATS = 150;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct {
    logic [DATA_W-1:0] sample;
    logic              clear;
  } sample_beat_t;

  typedef struct packed {
    logic [DATA_W-1:0] average;
    logic [CNT_W-1:0]  count;
  } avg_result_t;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_JITTER,
    RX_SLOW
  } rx_mode_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [DATA_W-1:0]   sample = '0;
  logic                clear = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DATA_W-1:0]   average;
  logic [CNT_W-1:0]    sample_count;

  // predictor state
  logic [DATA_W-1:0]   ring [MAX_WINDOW];
  longint              ring_sum = 0;
  int unsigned         ring_pos = 0;
  int unsigned         ring_fill = 0;
  logic [WSIZE_W-1:0]  cfg_wsize = WSIZE_RST;
  logic                cfg_signed = 1'b0;

  sample_beat_t        sample_queue[$];
  avg_result_t         awaited_results[$];
  sample_beat_t        next_beat;

  bit                  in_fire = 1'b0;
  bit                  draining = 1'b0;
  int                  burst_left = 8;
  int                  gap_left = 0;
  int                  beats_sent = 0;
  int                  rx_left = 0;
  rx_mode_t            rx_mode = RX_STEADY;
  int                  errors = 0;
  int                  cycles = 0;

  moving_average_window_unit #(.MAX_WINDOW(MAX_WINDOW)) u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .clear        (clear),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .average      (average),
    .sample_count (sample_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint sample_value(input logic [DATA_W-1:0] bits);
    if (cfg_signed) begin
      return longint'($signed(bits));
    end
    return longint'(bits);
  endfunction

  function automatic void empty_window();
    ring_sum  = 0;
    ring_pos  = 0;
    ring_fill = 0;
  endfunction

  // Advances the predicted filter by one beat and returns the expected result.
  function automatic avg_result_t next_average(input logic [DATA_W-1:0] bits, input logic clr);
    avg_result_t r;
    int unsigned size;
    longint      quot;
    r = '0;
    size = cfg_wsize;
    if (size == 0) size = 1;
    if (size > MAX_WINDOW) size = MAX_WINDOW;
    if (clr) begin
      empty_window();
      return r;
    end
    if (ring_pos >= size) ring_pos = 0;
    if (ring_fill < size) begin
      ring_fill++;
    end else begin
      ring_sum -= sample_value(ring[ring_pos]);   // drop the oldest sample
    end
    ring[ring_pos] = bits;
    ring_sum += sample_value(bits);
    quot = ring_sum / longint'(ring_fill);       // truncates toward zero
    ring_pos++;
    if (ring_pos >= size) ring_pos = 0;
    r.average = quot[DATA_W-1:0];
    r.count   = ring_fill[CNT_W-1:0];
    return r;
  endfunction

  // Input accept, result check and run limit, all at the rising edge.
  always @(posedge clk) begin
    avg_result_t want;
    in_fire = !rst && in_valid && in_ready;
    if (in_fire) begin
      awaited_results.push_back(next_average(sample, clear));
    end
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result beat with none expected: average %h count %0d",
                 $time, average, sample_count);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (average !== want.average) begin
          $display("%0t: average mismatch: expected %h actual %h",
                   $time, want.average, average);
          errors++;
        end
        if (sample_count !== want.count) begin
          $display("%0t: sample_count mismatch: expected %0d actual %0d",
                   $time, want.count, sample_count);
          errors++;
        end
      end
    end
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: run limit reached", $time);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Beat driver: bursts of random length, random gaps, and an occasional
  // hold until every outstanding result is back.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (draining && awaited_results.size() == 0) draining = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (draining || sample_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        next_beat = sample_queue.pop_front();
        sample   <= next_beat.sample;
        clear    <= next_beat.clear;
        in_valid <= 1'b1;
        beats_sent++;
        if (beats_sent % 150 == 75) draining = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
    end
  end

  // Result sink stall pattern, switching between steady, jittery and slow.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_STEADY: out_ready <= 1'b1;
      RX_JITTER: out_ready <= 1'($urandom_range(0, 1));
      default:   out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic push_beat(input logic [DATA_W-1:0] s, input logic c);
    sample_beat_t b;
    b.sample = s;
    b.clear  = c;
    sample_queue.push_back(b);
  endtask

  task automatic wait_drained();
    while (sample_queue.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
  endtask

  // Setup cycle, then access cycle; a write also empties the window.
  task automatic reg_write(input reg_idx_t idx, input logic [APB_DW-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WINDOW_SIZE) begin
      cfg_wsize = val[WSIZE_W-1:0];
    end else begin
      cfg_signed = val[0];
    end
    empty_window();
  endtask

  task automatic feed_random(input int n);
    logic [DATA_W-1:0] s;
    logic              c;
    for (int i = 0; i < n; i++) begin
      c = ($urandom_range(0, 49) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: s = DATA_W'($urandom);
        5: begin
          case ($urandom_range(0, 3))
            0: s = 16'h0000;
            1: s = 16'hFFFF;
            2: s = 16'h8000;
            default: s = 16'h7FFF;
          endcase
        end
        6, 7: s = DATA_W'($urandom_range(0, 64) - 32);   // small, both signs
        default: s = {1'b1, 15'($urandom)};
      endcase
      push_beat(s, c);
    end
  endtask

  initial begin
    int unsigned phase_wsize [12] = '{16, 1, 0, 31, 2, 17, 5, 16, 8, 12, 1, 16};
    logic        phase_signed;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset setting: 16 deep, unsigned
    push_beat(16'h1234, 1'b1);
    push_beat(16'h0000, 1'b0);
    push_beat(16'hFFFF, 1'b0);
    push_beat(16'h8000, 1'b0);
    push_beat(16'h7FFF, 1'b0);
    push_beat(16'h0001, 1'b0);
    push_beat(16'hFFFF, 1'b1);
    push_beat(16'hFFFF, 1'b0);
    wait_drained();

    // signed, window of two: negative truncation and wraparound
    reg_write(REG_SIGNED_MODE, 32'd1);
    reg_write(REG_WINDOW_SIZE, 32'd2);
    push_beat(16'hFFFF, 1'b0);
    push_beat(16'hFFFE, 1'b0);
    push_beat(16'h8000, 1'b0);
    push_beat(16'h8000, 1'b0);
    push_beat(16'h7FFF, 1'b0);
    push_beat(16'h7FFF, 1'b0);
    wait_drained();

    // size zero acts as one
    reg_write(REG_WINDOW_SIZE, 32'd0);
    push_beat(16'h8000, 1'b0);
    push_beat(16'h1234, 1'b0);
    push_beat(16'h0000, 1'b1);
    push_beat(16'h7FFF, 1'b0);
    wait_drained();

    // oversize saturates to the full depth
    reg_write(REG_WINDOW_SIZE, 32'd31);
    reg_write(REG_SIGNED_MODE, 32'd0);
    push_beat(16'hFFFF, 1'b0);
    push_beat(16'h0000, 1'b0);
    push_beat(16'hFFFF, 1'b0);

    for (int p = 0; p < 12; p++) begin
      wait_drained();
      phase_signed = 1'((p / 2) % 2);
      if ($urandom_range(0, 1)) begin
        reg_write(REG_WINDOW_SIZE, phase_wsize[p]);
        reg_write(REG_SIGNED_MODE, {31'd0, phase_signed});
      end else begin
        reg_write(REG_SIGNED_MODE, {31'd0, phase_signed});
        reg_write(REG_WINDOW_SIZE, phase_wsize[p]);
      end
      feed_random(PHASE_BEATS);
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (awaited_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: moving_average_window_unit.f
hw/rtl/mavg_pkg.sv
hw/rtl/mavg_ram.sv
hw/rtl/mavg_cfg.sv
hw/rtl/mavg_div.sv
hw/rtl/moving_average_window_unit.sv
verif/tb_moving_average_window_unit.sv
